// ----- rtl/core/bdq_pkg.sv -----
// Shared types and codes for the bounded deque block.
// Used by the controller, the datapath, the top level and the checker.
package bdq_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_POP_WAIT,
        S_SEARCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic capture;
        logic scan;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic pop_ok;
        logic search_ok;
        logic hit;
        logic last;
    } dp_sts_t;

endpackage

// ----- rtl/core/bdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bdq_ctrl.sv -----
// Sequencer for the bounded deque: handshakes and per-operation steps.
// Depends on bdq_pkg; drives the datapath through dp_cmd_t.
module bdq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  bdq_pkg::dp_sts_t sts,
    output bdq_pkg::dp_cmd_t cmd
);

    import bdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (sts.pop_ok)
                begin
                    state_next = S_POP_WAIT;
                end
                else if (sts.search_ok)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_WAIT:
            begin
                cmd.capture = 1'b1;
                state_next  = S_DONE;
            end
            S_SEARCH:
            begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/bdq_dp.sv -----
// Datapath for the bounded deque: ring pointers, entry RAM, search scan, result registers.
// Depends on bdq_pkg and bdq_ram; steered by bdq_ctrl.
module bdq_dp #(
    parameter int DEPTH = 64,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bdq_pkg::dp_cmd_t               cmd,
    output bdq_pkg::dp_sts_t               sts,
    input  logic [bdq_pkg::KIND_W-1:0]     kind,
    input  logic signed [bdq_pkg::DATA_W-1:0] value,
    output logic [bdq_pkg::STATUS_W-1:0]   status,
    output logic signed [bdq_pkg::DATA_W-1:0] popped_value,
    output logic [CW-1:0]                  found_position,
    output logic [CW-1:0]                  occupancy
);

    import bdq_pkg::*;

    localparam int SW = CW + 1;

    function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        begin
            sum = SW'(base) + SW'(off);
            if (sum >= SW'(DEPTH))
            begin
                sum = sum - SW'(DEPTH);
            end
            return sum[IW-1:0];
        end
    endfunction

    logic [KIND_W-1:0]   kind_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [IW-1:0]       front_reg;
    logic [IW-1:0]       front_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       cmp_reg;
    logic [CW-1:0]       cmp_next;

    logic [STATUS_W-1:0] pend_status_reg;
    logic [STATUS_W-1:0] pend_status_next;
    logic [DATA_W-1:0]   pend_popped_reg;
    logic [DATA_W-1:0]   pend_popped_next;
    logic [CW-1:0]       pend_pos_reg;
    logic [CW-1:0]       pend_pos_next;
    logic [CW-1:0]       pend_occ_reg;
    logic [CW-1:0]       pend_occ_next;

    logic [STATUS_W-1:0] out_status_reg;
    logic [DATA_W-1:0]   out_popped_reg;
    logic [CW-1:0]       out_pos_reg;
    logic [CW-1:0]       out_occ_reg;

    logic                is_empty;
    logic                is_full;
    logic [IW-1:0]       front_dec;
    logic [IW-1:0]       front_inc;
    logic [CW-1:0]       rd_off;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [IW-1:0]       mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    always_comb
    begin
        if (cmd.scan)
        begin
            rd_off = cmp_reg + 1'b1;
        end
        else if (kind_reg == KIND_POP_BACK)
        begin
            rd_off = count_reg - 1'b1;
        end
        else
        begin
            rd_off = '0;
        end
    end

    assign mem_raddr = ring_slot(front_reg, rd_off);
    assign mem_waddr = (kind_reg == KIND_PUSH_FRONT) ? front_dec : ring_slot(front_reg, count_reg);
    assign mem_we    = cmd.issue && !is_full
                       && (kind_reg == KIND_PUSH_FRONT || kind_reg == KIND_PUSH_BACK);

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign sts.pop_ok    = !is_empty && (kind_reg == KIND_POP_FRONT || kind_reg == KIND_POP_BACK);
    assign sts.search_ok = !is_empty && (kind_reg == KIND_SEARCH);
    assign sts.hit       = (mem_rdata == value_reg);
    assign sts.last      = ((cmp_reg + 1'b1) == count_reg);

    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        cmp_next         = cmp_reg;
        pend_status_next = pend_status_reg;
        pend_popped_next = pend_popped_reg;
        pend_pos_next    = pend_pos_reg;
        pend_occ_next    = pend_occ_reg;
        if (cmd.issue)
        begin
            pend_status_next = ST_OK;
            pend_popped_next = '0;
            pend_pos_next    = '0;
            cmp_next         = '0;
            case (kind_reg)
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (kind_reg == KIND_PUSH_FRONT)
                        begin
                            front_next = front_dec;
                        end
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (kind_reg == KIND_POP_FRONT)
                        begin
                            front_next = front_inc;
                        end
                    end
                end
                KIND_SEARCH:
                begin
                    pend_status_next = is_empty ? ST_EMPTY : ST_NOT_FOUND;
                end
                default:
                begin
                    pend_status_next = ST_OK;
                end
            endcase
            pend_occ_next = count_next;
        end
        if (cmd.capture)
        begin
            pend_popped_next = mem_rdata;
        end
        if (cmd.scan)
        begin
            cmp_next = cmp_reg + 1'b1;
            if (sts.hit)
            begin
                pend_status_next = ST_OK;
                pend_pos_next    = cmp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            value_reg <= value;
        end
        cmp_reg         <= cmp_next;
        pend_status_reg <= pend_status_next;
        pend_popped_reg <= pend_popped_next;
        pend_pos_reg    <= pend_pos_next;
        pend_occ_reg    <= pend_occ_next;
        if (cmd.publish)
        begin
            out_status_reg <= pend_status_reg;
            out_popped_reg <= pend_popped_reg;
            out_pos_reg    <= pend_pos_reg;
            out_occ_reg    <= pend_occ_reg;
        end
    end

    assign status         = out_status_reg;
    assign popped_value   = out_popped_reg;
    assign found_position = out_pos_reg;
    assign occupancy      = out_occ_reg;

endmodule

// ----- rtl/core/bounded_deque_with_search.sv -----
// Bounded double-ended queue of signed 32-bit values with search from the front.
// Top level: joins bdq_ctrl and bdq_dp; depends on bdq_pkg.
//
// Operations (kind): push front, push back, pop front, pop back, search. One result beat per
// input beat. Items are handled one at a time; a finished result waits in an output register
// while the next input beat is taken. After acceptance, a push, an unused kind code or a pop
// on an empty queue goes through the issue and done states; a pop that removes an entry also
// passes a wait state for the registered read of the single entry RAM; a search passes a scan
// state that compares the entries up to and including the first match, or all of them,
// one per cycle through the RAM read port. A finished result waits in the done state while
// the previous beat is still stalled at the output. The entry RAM needs no clearing after
// reset.
module bounded_deque_with_search #(
    parameter int DEPTH = 64,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bdq_pkg::KIND_W-1:0]        kind,
    input  logic signed [bdq_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bdq_pkg::STATUS_W-1:0]      status,
    output logic signed [bdq_pkg::DATA_W-1:0] popped_value,
    output logic [CW-1:0]                     found_position,
    output logic [CW-1:0]                     occupancy
);

    import bdq_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bdq_dp #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .value          (value),
        .status         (status),
        .popped_value   (popped_value),
        .found_position (found_position),
        .occupancy      (occupancy)
    );

endmodule

// ----- rtl/core/bdq_checker.sv -----
// Port-level checks for the bounded deque, bound to the top level.
// Depends on bdq_pkg.
module bdq_checker #(
    parameter int DEPTH = 64,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [bdq_pkg::STATUS_W-1:0]      status,
    input logic signed [bdq_pkg::DATA_W-1:0] popped_value,
    input logic [CW-1:0]                     found_position,
    input logic [CW-1:0]                     occupancy
);

    import bdq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(popped_value)
            && $stable(found_position) && $stable(occupancy))
        else $error("result beat changed while stalled");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy == CW'(DEPTH) && popped_value == '0
            && found_position == '0)
        else $error("full status without a full queue");

    a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> occupancy == '0 && popped_value == '0
            && found_position == '0)
        else $error("empty status with non-zero fields");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_position != '0 |-> status == ST_OK && found_position <= occupancy)
        else $error("found position outside the occupied span");

endmodule

bind bounded_deque_with_search bdq_checker #(.DEPTH(DEPTH), .CW(CW)) u_bdq_checker (.*);
